[hw/rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/stlg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package stlg_pkg;

   localparam int GEN_W     = 18;
   localparam int OUT_W     = 32;
   localparam int REM_W     = 37;
   localparam int RED_STEPS = 15;

   localparam logic [GEN_W-1:0] MOD1 = 18'd259200;
   localparam logic [GEN_W-1:0] MUL1 = 18'd7141;
   localparam logic [GEN_W-1:0] INC1 = 18'd54773;
   localparam logic [GEN_W-1:0] MOD2 = 18'd134456;
   localparam logic [GEN_W-1:0] MUL2 = 18'd8121;
   localparam logic [GEN_W-1:0] INC2 = 18'd28411;
   localparam logic [GEN_W-1:0] MOD3 = 18'd243000;
   localparam logic [GEN_W-1:0] MUL3 = 18'd4561;
   localparam logic [GEN_W-1:0] INC3 = 18'd51349;

   // MOD1 * MOD2
   localparam logic [REM_W-1:0] FRAC_DEN  = 37'd34850995200;
   // INC1 plus a multiple of MOD1 that keeps the seed term non-negative
   localparam logic [REM_W-1:0] SEED_BIAS = 37'd2147526773;

   localparam logic [REM_W-1:0] RED_DIV1 = REM_W'(MOD1) << (RED_STEPS - 1);
   localparam logic [REM_W-1:0] RED_DIV2 = REM_W'(MOD2) << (RED_STEPS - 1);
   localparam logic [REM_W-1:0] RED_DIV3 = REM_W'(MOD3) << (RED_STEPS - 1);

endpackage

`default_nettype wire

[hw/rtl/shuffled_triple_lcg_generator_core.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Shuffled triple LCG uniform generator. Each req transaction is one command (req_tuser:
// 0 draw, 1 seed then draw) and yields one rsp transaction carrying a 32-bit fraction.
// All arithmetic runs through one compare-subtract unit, one step per clock, fed by one
// multiplier: each generator update, table index and table fraction is one load, run and
// store pass through it. The first command after reset, and a seed command with a negative
// seed, first rebuild the table. req_tready is low while a command is in progress; a
// finished value waits in the output register while the next command is taken.
module shuffled_triple_lcg_generator_core #(
   parameter int TABLE_DEPTH   = 97,
   parameter int FRACTION_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seed_value
   input  logic [0:0]  req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] random_fraction
);

   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   localparam int STEP_MAX = (FRACTION_BITS > stlg_pkg::RED_STEPS) ?
                             FRACTION_BITS : stlg_pkg::RED_STEPS;
   localparam int CNT_W    = $clog2(STEP_MAX);
   localparam int GEN_W    = stlg_pkg::GEN_W;
   localparam int REM_W    = stlg_pkg::REM_W;
   localparam int OUT_W    = stlg_pkg::OUT_W;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LOAD  = 5'b00010,
      ST_RUN   = 5'b00100,
      ST_STORE = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   typedef enum logic [12:0] {
      JOB_SEED  = 13'b0000000000001,
      JOB_PRE1  = 13'b0000000000010,
      JOB_COPY2 = 13'b0000000000100,
      JOB_PRE2  = 13'b0000000001000,
      JOB_COPY3 = 13'b0000000010000,
      JOB_FILL1 = 13'b0000000100000,
      JOB_FILL2 = 13'b0000001000000,
      JOB_FILLF = 13'b0000010000000,
      JOB_DRAW1 = 13'b0000100000000,
      JOB_DRAW2 = 13'b0001000000000,
      JOB_DRAW3 = 13'b0010000000000,
      JOB_INDEX = 13'b0100000000000,
      JOB_DRAWF = 13'b1000000000000
   } job_type;

   state_type         state_ff, state_in;
   job_type           job_ff, job_in;
   logic [GEN_W-1:0]  g1_ff, g1_in;
   logic [GEN_W-1:0]  g2_ff, g2_in;
   logic [GEN_W-1:0]  g3_ff, g3_in;
   logic              seeded_ff, seeded_in;
   logic [IDX_W-1:0]  fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       seed_ff, seed_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W-1:0]  div_ff, div_in;
   logic [OUT_W-1:0]  q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [OUT_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [GEN_W-1:0]   mul_a, mul_b, mul_c;
   logic               is_frac, is_seed;
   logic [REM_W-1:0]   red_div;
   logic [2*GEN_W-1:0] prod;
   logic [REM_W-1:0]   mul_sum, seed_num, load_num;
   logic [REM_W-1:0]   op_a, cs_diff;
   logic               cs_ge;
   logic [IDX_W-1:0]   idx_calc;
   logic               tbl_wr_en, tbl_rd_en;
   logic [IDX_W-1:0]   tbl_wr_addr;
   logic [OUT_W-1:0]   tbl_wr_data, tbl_rd_data;
   logic               req_fire;

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_c   = '0;
      is_frac = 1'b0;
      is_seed = 1'b0;
      red_div = stlg_pkg::RED_DIV1;
      case (job_ff)
         JOB_SEED: begin
            is_seed = 1'b1;
         end
         JOB_PRE1, JOB_PRE2, JOB_FILL1, JOB_DRAW1: begin
            mul_a = g1_ff;
            mul_b = stlg_pkg::MUL1;
            mul_c = stlg_pkg::INC1;
         end
         JOB_COPY2: begin
            mul_a   = g1_ff;
            mul_b   = GEN_W'(1);
            red_div = stlg_pkg::RED_DIV2;
         end
         JOB_COPY3: begin
            mul_a   = g1_ff;
            mul_b   = GEN_W'(1);
            red_div = stlg_pkg::RED_DIV3;
         end
         JOB_FILL2, JOB_DRAW2: begin
            mul_a   = g2_ff;
            mul_b   = stlg_pkg::MUL2;
            mul_c   = stlg_pkg::INC2;
            red_div = stlg_pkg::RED_DIV2;
         end
         JOB_DRAW3: begin
            mul_a   = g3_ff;
            mul_b   = stlg_pkg::MUL3;
            mul_c   = stlg_pkg::INC3;
            red_div = stlg_pkg::RED_DIV3;
         end
         JOB_INDEX: begin
            mul_a   = g3_ff;
            mul_b   = GEN_W'(TABLE_DEPTH);
            red_div = stlg_pkg::RED_DIV3;
         end
         JOB_FILLF, JOB_DRAWF: begin
            mul_a   = g1_ff;
            mul_b   = stlg_pkg::MOD2;
            mul_c   = g2_ff;
            is_frac = 1'b1;
            red_div = stlg_pkg::FRAC_DEN;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign prod     = mul_a * mul_b;
   assign mul_sum  = REM_W'(prod) + REM_W'(mul_c);
   assign seed_num = stlg_pkg::SEED_BIAS - {{(REM_W-32){seed_ff[31]}}, seed_ff};
   assign load_num = is_seed ? seed_num : mul_sum;

   assign op_a = is_frac ? {rem_ff[REM_W-2:0], 1'b0} : rem_ff;

   stlg_csub u_csub (
      .op_a (op_a),
      .op_b (div_ff),
      .diff (cs_diff),
      .ge   (cs_ge)
   );

   assign idx_calc = (q_ff >= OUT_W'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1) :
                     q_ff[IDX_W-1:0];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      g1_in        = g1_ff;
      g2_in        = g2_ff;
      g3_in        = g3_ff;
      seeded_in    = seeded_ff;
      fill_in      = fill_ff;
      seed_in      = seed_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      q_in         = q_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      tbl_wr_en    = 1'b0;
      tbl_wr_addr  = idx_ff;
      tbl_wr_data  = q_ff;
      tbl_rd_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               seed_in  = req_tuser[0] ? req_tdata : 32'd1;
               job_in   = ((req_tuser[0] && req_tdata[31]) || !seeded_ff) ?
                          JOB_SEED : JOB_DRAW1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            rem_in   = load_num;
            div_in   = red_div;
            q_in     = '0;
            cnt_in   = is_frac ? CNT_W'(FRACTION_BITS - 1) :
                       CNT_W'(stlg_pkg::RED_STEPS - 1);
            state_in = ST_RUN;
         end
         ST_RUN: begin
            rem_in = cs_ge ? cs_diff : op_a;
            q_in   = {q_ff[OUT_W-2:0], cs_ge};
            div_in = is_frac ? div_ff : (div_ff >> 1);
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            state_in = ST_LOAD;
            case (job_ff)
               JOB_SEED: begin
                  g1_in  = rem_ff[GEN_W-1:0];
                  job_in = JOB_PRE1;
               end
               JOB_PRE1: begin
                  g1_in  = rem_ff[GEN_W-1:0];
                  job_in = JOB_COPY2;
               end
               JOB_COPY2: begin
                  g2_in  = rem_ff[GEN_W-1:0];
                  job_in = JOB_PRE2;
               end
               JOB_PRE2: begin
                  g1_in  = rem_ff[GEN_W-1:0];
                  job_in = JOB_COPY3;
               end
               JOB_COPY3: begin
                  g3_in  = rem_ff[GEN_W-1:0];
                  job_in = JOB_FILL1;
               end
               JOB_FILL1: begin
                  g1_in  = rem_ff[GEN_W-1:0];
                  job_in = JOB_FILL2;
               end
               JOB_FILL2: begin
                  g2_in  = rem_ff[GEN_W-1:0];
                  job_in = JOB_FILLF;
               end
               JOB_FILLF: begin
                  tbl_wr_en   = 1'b1;
                  tbl_wr_addr = fill_ff;
                  if (fill_ff == IDX_W'(TABLE_DEPTH - 1)) begin
                     fill_in   = '0;
                     seeded_in = 1'b1;
                     job_in    = JOB_DRAW1;
                  end else begin
                     fill_in = fill_ff + IDX_W'(1);
                     job_in  = JOB_FILL1;
                  end
               end
               JOB_DRAW1: begin
                  g1_in  = rem_ff[GEN_W-1:0];
                  job_in = JOB_DRAW2;
               end
               JOB_DRAW2: begin
                  g2_in  = rem_ff[GEN_W-1:0];
                  job_in = JOB_DRAW3;
               end
               JOB_DRAW3: begin
                  g3_in  = rem_ff[GEN_W-1:0];
                  job_in = JOB_INDEX;
               end
               JOB_INDEX: begin
                  idx_in    = idx_calc;
                  tbl_rd_en = 1'b1;
                  job_in    = JOB_DRAWF;
               end
               JOB_DRAWF: begin
                  tbl_wr_en = 1'b1;
                  state_in  = ST_EMIT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = tbl_rd_data;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   stlg_table #(
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (idx_calc),
      .rd_data (tbl_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_DRAW1;
         g1_ff        <= '0;
         g2_ff        <= '0;
         g3_ff        <= '0;
         seeded_ff    <= 1'b0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         g1_ff        <= g1_in;
         g2_ff        <= g2_in;
         g3_ff        <= g3_in;
         seeded_ff    <= seeded_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_ff     <= seed_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      q_ff        <= q_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_IMP(a_gen_range, clock, reset, state_ff == ST_IDLE,
      (g1_ff < stlg_pkg::MOD1) && (g2_ff < stlg_pkg::MOD2) && (g3_ff < stlg_pkg::MOD3),
      "generator state out of range while idle")
   `ASSERT_IMP(a_wr_addr, clock, reset, tbl_wr_en,
      tbl_wr_addr <= IDX_W'(TABLE_DEPTH - 1), "table write beyond depth")
   `ASSERT_IMP(a_rsp_seeded, clock, reset, rsp_valid_ff, seeded_ff,
      "result offered before the table was built")
   `ASSERT_NXT(a_fill_done, clock, reset,
      (state_ff == ST_STORE) && (job_ff == JOB_FILLF) && (fill_ff == IDX_W'(TABLE_DEPTH - 1)),
      seeded_ff && (job_ff == JOB_DRAW1) && (fill_ff == '0), "table fill did not close")

endmodule

`default_nettype wire

[hw/rtl/stlg_csub.sv]
`timescale 1ns / 1ps
`default_nettype none

module stlg_csub (
   input  logic [stlg_pkg::REM_W-1:0] op_a,
   input  logic [stlg_pkg::REM_W-1:0] op_b,
   output logic [stlg_pkg::REM_W-1:0] diff,
   output logic                       ge
);

   logic [stlg_pkg::REM_W:0] wide;

   assign wide = {1'b0, op_a} - {1'b0, op_b};
   assign ge   = ~wide[stlg_pkg::REM_W];
   assign diff = wide[stlg_pkg::REM_W-1:0];

endmodule

`default_nettype wire

[hw/rtl/stlg_table.sv]
`timescale 1ns / 1ps
`default_nettype none

module stlg_table #(
   parameter int DEPTH = 97
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [stlg_pkg::OUT_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [stlg_pkg::OUT_W-1:0] rd_data
);

   logic [stlg_pkg::OUT_W-1:0] mem [DEPTH];
   logic [stlg_pkg::OUT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int SLOT_COUNT = 97;
   localparam int FRAC_BITS  = 32;
   localparam int DRAIN_CYCLES = 200;
   localparam int GEN_W = stlg_pkg::GEN_W;

   typedef enum bit {
      CMD_DRAW = 1'b0,
      CMD_SEED = 1'b1
   } cmd_op_type;

   typedef struct {
      cmd_op_type  op;
      logic [31:0] seed;
   } command_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] seed_value
   logic [0:0]  req_tuser = '0;   // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] random_fraction

   command_type pending_cmds[$];
   command_type active_cmd;
   logic [31:0] fraction_queue[$];

   logic [GEN_W-1:0] lcg_a, lcg_b, lcg_c;
   logic [31:0]      slots[SLOT_COUNT];
   bit               seeded;

   int  req_idle = 0;
   int  rsp_stall = 0;
   bit  req_quiet = 1'b0;
   bit  rsp_quiet = 1'b0;
   int  errors = 0;
   int  accepted = 0;
   int  seed_cmds = 0;
   int  rebuilds = 0;
   int  checked = 0;
   longint cycles = 0;
   longint cycle_limit = 0;
   bit  finishing = 1'b0;

   shuffled_triple_lcg_generator_core #(
      .TABLE_DEPTH  (SLOT_COUNT),
      .FRACTION_BITS(FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #2 clock = ~clock;

   function automatic logic [GEN_W-1:0] lcg_advance(logic [GEN_W-1:0] x,
                                                    logic [GEN_W-1:0] mul,
                                                    logic [GEN_W-1:0] inc,
                                                    logic [GEN_W-1:0] modulus);
      longint unsigned p;
      p = 64'(mul) * 64'(x) + 64'(inc);
      return GEN_W'(p % 64'(modulus));
   endfunction

   function automatic logic [31:0] fraction_of(logic [GEN_W-1:0] a, logic [GEN_W-1:0] b);
      longint unsigned den;
      longint unsigned rem;
      logic [31:0]     q;
      q = '0;
      den = 64'(stlg_pkg::MOD1) * 64'(stlg_pkg::MOD2);
      rem = (64'(a) * 64'(stlg_pkg::MOD2) + 64'(b)) % den;
      for (int i = 0; i < FRAC_BITS; i++) begin
         rem = rem << 1;
         q = {q[30:0], rem >= den};
         if (rem >= den) begin
            rem = rem - den;
         end
      end
      return q;
   endfunction

   task automatic refill_slots(longint s);
      longint t;
      longint r;
      t = 64'(stlg_pkg::INC1) - s;
      r = t % longint'(stlg_pkg::MOD1);
      if (r < 0) begin
         r = r + longint'(stlg_pkg::MOD1);
      end
      lcg_a = GEN_W'(r);
      lcg_a = lcg_advance(lcg_a, stlg_pkg::MUL1, stlg_pkg::INC1, stlg_pkg::MOD1);
      lcg_b = lcg_a % stlg_pkg::MOD2;
      lcg_a = lcg_advance(lcg_a, stlg_pkg::MUL1, stlg_pkg::INC1, stlg_pkg::MOD1);
      lcg_c = lcg_a % stlg_pkg::MOD3;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         lcg_a = lcg_advance(lcg_a, stlg_pkg::MUL1, stlg_pkg::INC1, stlg_pkg::MOD1);
         lcg_b = lcg_advance(lcg_b, stlg_pkg::MUL2, stlg_pkg::INC2, stlg_pkg::MOD2);
         slots[i] = fraction_of(lcg_a, lcg_b);
      end
      seeded = 1'b1;
      rebuilds++;
   endtask

   task automatic predict_draw(command_type c);
      longint      s;
      int unsigned idx;
      s = (c.op == CMD_SEED) ? longint'($signed(c.seed)) : 64'sd1;
      if ((c.op == CMD_SEED && c.seed[31]) || !seeded) begin
         refill_slots(s);
      end
      lcg_a = lcg_advance(lcg_a, stlg_pkg::MUL1, stlg_pkg::INC1, stlg_pkg::MOD1);
      lcg_b = lcg_advance(lcg_b, stlg_pkg::MUL2, stlg_pkg::INC2, stlg_pkg::MOD2);
      lcg_c = lcg_advance(lcg_c, stlg_pkg::MUL3, stlg_pkg::INC3, stlg_pkg::MOD3);
      idx = (SLOT_COUNT * int'(lcg_c)) / int'(stlg_pkg::MOD3);
      fraction_queue.push_back(slots[idx]);
      slots[idx] = fraction_of(lcg_a, lcg_b);
   endtask

   function automatic int draw_wait(bit quiet);
      return quiet ? 0 : int'($urandom_range(0, 15));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_draw(active_cmd);
            accepted++;
            if (active_cmd.op == CMD_SEED) begin
               seed_cmds++;
            end
         end
         if (!req_tvalid || req_tready) begin
            if (req_idle > 0) begin
               req_tvalid <= 1'b0;
               req_idle <= req_idle - 1;
            end else if (pending_cmds.size() != 0) begin
               active_cmd = pending_cmds.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= active_cmd.seed;
               req_tuser <= active_cmd.op;
               if ($urandom_range(0, 39) == 0) begin
                  req_quiet = ~req_quiet;
               end
               req_idle <= draw_wait(req_quiet);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      int          w;
      logic [31:0] want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (fraction_queue.size() == 0) begin
            $error("unexpected rsp transaction: random_fraction actual %h", rsp_tdata);
            errors++;
         end else begin
            want = fraction_queue.pop_front();
            checked++;
            if (rsp_tdata !== want) begin
               $error("random_fraction mismatch: expected %h actual %h", want, rsp_tdata);
               errors++;
            end
         end
         if ($urandom_range(0, 29) == 0) begin
            rsp_quiet = ~rsp_quiet;
         end
         w = draw_wait(rsp_quiet);
         rsp_stall <= w;
         rsp_tready <= (w == 0);
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= (rsp_stall == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > cycle_limit && !finishing) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic add_cmd(cmd_op_type op, logic [31:0] seed);
      command_type c;
      c.op = op;
      c.seed = seed;
      pending_cmds.push_back(c);
   endtask

   initial begin
      int          n_slow;
      int          pick;
      logic [31:0] r;
      n_slow = 1;

      // first command rebuilds with the largest positive seed
      add_cmd(CMD_SEED, 32'h7FFF_FFFF);
      add_cmd(CMD_DRAW, 32'h0000_0000);
      add_cmd(CMD_DRAW, 32'hFFFF_FFFF);
      add_cmd(CMD_SEED, 32'h0000_0000);
      add_cmd(CMD_SEED, 32'h0000_0001);
      add_cmd(CMD_SEED, 32'h8000_0000);
      add_cmd(CMD_DRAW, 32'h5555_5555);
      add_cmd(CMD_SEED, 32'hFFFF_FFFF);
      add_cmd(CMD_DRAW, 32'hAAAA_AAAA);
      // seed term lands exactly on a multiple of the first modulus
      add_cmd(CMD_SEED, 32'(-204427));
      for (int i = 0; i < 6; i++) begin
         add_cmd(CMD_DRAW, $urandom);
      end
      add_cmd(CMD_SEED, 32'h7FFF_FFFE);
      add_cmd(CMD_DRAW, 32'h0000_0000);
      n_slow += 4;

      for (int i = 0; i < 790; i++) begin
         pick = $urandom_range(0, 99);
         r = $urandom;
         if (pick < 3) begin
            add_cmd(CMD_SEED, r | 32'h8000_0000);
            n_slow++;
         end else if (pick < 20) begin
            add_cmd(CMD_SEED, r & 32'h7FFF_FFFF);
         end else begin
            add_cmd(CMD_DRAW, r);
         end
      end

      cycle_limit = 4 * (longint'(pending_cmds.size()) * 150 + longint'(n_slow) * 6800
                         + 2000);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_cmds.size() != 0 || req_tvalid) @(posedge clock);
      while (fraction_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      finishing = 1'b1;

      $display("Issued %0d commands (%0d seed commands), %0d table rebuilds predicted",
               accepted, seed_cmds, rebuilds);
      $display("Compared %0d output fractions, %0d mismatches", checked, errors);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[shuffled_triple_lcg_generator_core.f]
+incdir+hw/rtl
hw/rtl/stlg_pkg.sv
hw/rtl/stlg_csub.sv
hw/rtl/stlg_table.sv
hw/rtl/shuffled_triple_lcg_generator_core.sv
tb/testbench.sv
